FILE: hw/rtl/potb_pkg.sv
// Shared types and constants for the periodic / one-shot timer bank.
// Holds command and status codes, field widths and the timer record layout.
// No dependencies.
package potb_pkg;

  localparam int ID_W    = 6;
  localparam int XW      = ID_W + 1;
  localparam int NOW_W   = 63;
  localparam int IVL_W   = 48;
  localparam int START_W = 64;
  localparam int MODE_W  = 2;
  localparam int ST_W    = 3;

  // Command codes
  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STOP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [ST_W-1:0] ST_FIRED     = 3'd3;
  localparam logic [ST_W-1:0] ST_NONE      = 3'd4;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [IVL_W-1:0]   interval;
    logic               periodic;
  } timer_rec_t;

  typedef struct packed {
    logic            en;
    logic [ID_W-1:0] addr;
    timer_rec_t      rec;
  } rec_wr_t;

  typedef struct packed {
    logic            arm;
    logic            disarm;
    logic [ID_W-1:0] addr;
  } flag_op_t;

endpackage

FILE: hw/rtl/potb_store.sv
// Timer state store: synchronous record memory plus per-timer active flags.
// Depends on potb_pkg for the record and request types.
module potb_store import potb_pkg::*; #(
  parameter int NUM_TIMERS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  logic [ID_W-1:0] rd_addr,
  output timer_rec_t      rd_data,
  input  rec_wr_t         wr,
  input  flag_op_t        flag_op,
  input  logic [ID_W-1:0] chk_addr,
  output logic            chk_active
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  timer_rec_t            mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] active;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[IW-1:0]] <= wr.rec;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr[IW-1:0]];
    end
  end

  // Active flags clear at reset; arm and disarm share one address, and disarm wins if both are set
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else begin
      if (flag_op.arm) begin
        active[flag_op.addr[IW-1:0]] <= 1'b1;
      end
      if (flag_op.disarm) begin
        active[flag_op.addr[IW-1:0]] <= 1'b0;
      end
    end
  end

  assign chk_active = active[chk_addr[IW-1:0]];

endmodule

FILE: hw/rtl/periodic_one_shot_timer_bank_unit.sv
// Top level of the periodic / one-shot timer bank.
// Depends on potb_pkg and potb_store.
//
//   channel | signals                                     | direction
//   --------+---------------------------------------------+----------
//   cmd     | cmd_valid cmd_stall mode now_ns interval_ns | in
//           | repeat_req target_id                        |
//   rsp     | rsp_valid rsp_stall status timer_index last | out
//
// Create and stop load their result into the output register at the
// command transfer. During a tick the scan visits one timer per cycle
// unless a stalled result holds it, bounded by the single read port of
// the record memory, and the FLUSH state then posts the final result.
// Reset is synchronous and needs no clearing pass; active flags clear in
// flip-flops at once. A stalled result holds the scan only when the scan
// has another result to post.
module periodic_one_shot_timer_bank_unit import potb_pkg::*; #(
  parameter int NUM_TIMERS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  logic [MODE_W-1:0] mode,
  input  logic [NOW_W-1:0]  now_ns,
  input  logic [IVL_W-1:0]  interval_ns,
  input  logic              repeat_req,
  input  logic [ID_W-1:0]   target_id,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [ST_W-1:0]   status,
  output logic [ID_W-1:0]   timer_index,
  output logic              last
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [CW-1:0]     used_count, used_count_next;
  logic [IW-1:0]     idx, idx_next;
  logic              pend, pend_next;
  logic [IW-1:0]     pend_idx, pend_idx_next;
  logic [NOW_W-1:0]  now_reg, now_reg_next;

  logic              rd_en;
  logic [ID_W-1:0]   rd_addr;
  timer_rec_t        rd_data;
  rec_wr_t           wr;
  flag_op_t          flag_op;
  logic              chk_active;

  logic              out_free;
  logic              cmd_take;
  logic [START_W-1:0] due;
  logic              fire;
  logic              last_entry;
  logic              adv;
  logic              full;
  logic              found;

  logic              push;
  logic [ST_W-1:0]   push_status;
  logic [ID_W-1:0]   push_index;
  logic              push_last;

  potb_store #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr         (wr),
    .flag_op    (flag_op),
    .chk_addr   (ID_W'(idx)),
    .chk_active (chk_active)
  );

  // The output register is free when empty or draining this cycle
  assign out_free  = !rsp_valid || !rsp_stall;
  assign cmd_stall = (state != S_IDLE) || !out_free;
  assign cmd_take  = cmd_valid && !cmd_stall;

  assign full  = used_count >= CW'(NUM_TIMERS);
  assign found = {1'b0, target_id} < XW'(used_count);

  // Scan datapath: due time of the entry held in the read register
  assign due        = rd_data.start + START_W'(rd_data.interval);
  assign fire       = chk_active && ({1'b0, now_reg} >= due);
  assign last_entry = (CW'(idx) + CW'(1)) == used_count;
  // A fired timer with a result still pending needs the output register
  assign adv        = (state == S_SCAN) && (!fire || !pend || out_free);

  always_comb begin
    state_next      = state;
    used_count_next = used_count;
    idx_next        = idx;
    pend_next       = pend;
    pend_idx_next   = pend_idx;
    now_reg_next    = now_reg;
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr              = '0;
    flag_op         = '0;
    push            = 1'b0;
    push_status     = ST_OK;
    push_index      = '0;
    push_last       = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (cmd_take) begin
          unique case (mode)
            MODE_CREATE: begin
              push = 1'b1;
              if (full) begin
                push_status = ST_FULL;
              end else begin
                // Append at the next free index and arm it
                wr.en            = 1'b1;
                wr.addr          = ID_W'(used_count);
                wr.rec.start     = START_W'(now_ns);
                wr.rec.interval  = interval_ns;
                wr.rec.periodic  = repeat_req;
                flag_op.arm      = 1'b1;
                flag_op.addr     = ID_W'(used_count);
                used_count_next  = used_count + CW'(1);
                push_status      = ST_OK;
                push_index       = ID_W'(used_count);
              end
            end
            MODE_STOP: begin
              push       = 1'b1;
              push_index = target_id;
              if (found) begin
                flag_op.disarm = 1'b1;
                flag_op.addr   = target_id;
                push_status    = ST_OK;
              end else begin
                push_status    = ST_NOT_FOUND;
              end
            end
            MODE_TICK: begin
              now_reg_next = now_ns;
              idx_next     = '0;
              pend_next    = 1'b0;
              if (used_count == '0) begin
                state_next = S_FLUSH;
              end else begin
                // Fetch entry 0 for the scan
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_SCAN;
              end
            end
            default: begin
              // Unused command code: drop it
            end
          endcase
        end
      end

      S_SCAN: begin
        if (adv) begin
          if (fire) begin
            if (rd_data.periodic) begin
              // Advance start by one interval
              wr.en           = 1'b1;
              wr.addr         = ID_W'(idx);
              wr.rec.start    = due;
              wr.rec.interval = rd_data.interval;
              wr.rec.periodic = rd_data.periodic;
            end else begin
              flag_op.disarm = 1'b1;
              flag_op.addr   = ID_W'(idx);
            end
            // Hold one fired result back so the final one can carry last
            if (pend) begin
              push        = 1'b1;
              push_status = ST_FIRED;
              push_index  = ID_W'(pend_idx);
              push_last   = 1'b0;
            end
            pend_next     = 1'b1;
            pend_idx_next = idx;
          end
          if (last_entry) begin
            state_next = S_FLUSH;
          end else begin
            // Fetch the next entry; it never equals the one written back
            idx_next = idx + IW'(1);
            rd_en    = 1'b1;
            rd_addr  = ID_W'(idx_next);
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          if (pend) begin
            push_status = ST_FIRED;
            push_index  = ID_W'(pend_idx);
          end else begin
            push_status = ST_NONE;
            push_index  = '0;
          end
          pend_next  = 1'b0;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      pend       <= 1'b0;
    end else begin
      state      <= state_next;
      used_count <= used_count_next;
      pend       <= pend_next;
    end
  end

  // Scan payload
  always_ff @(posedge clk) begin
    idx      <= idx_next;
    pend_idx <= pend_idx_next;
    now_reg  <= now_reg_next;
  end

  // Output register: load on push, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      status      <= push_status;
      timer_index <= push_index;
      last        <= push_last;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CW'(NUM_TIMERS))
    else $error("timer count beyond table size");

  a_scan_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (rd_en && state == S_SCAN) |-> ((CW'(idx) + CW'(1)) < used_count))
    else $error("scan fetch beyond used timers");

  a_fired_in_range: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_FIRED) |-> (XW'(timer_index) < XW'(used_count)))
    else $error("fired result names an unused timer");

  a_flush_closes_tick: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && out_free) |=> (rsp_valid && last && state == S_IDLE))
    else $error("tick did not close with a final result");

endmodule
